FILE: hdl/izh_pkg.sv
// shared types, constants and saturation helper for the izhikevich neuron step block
`timescale 1ns / 1ps

package izh_pkg;

	// default build constants
	localparam int TICK_RATE_DEF   = 1024;
	localparam int QUEUE_DEPTH_DEF = 2;

	// ticks never exceed one millisecond, at most 65536 ticks
	localparam int TICKS_W = 17;
	localparam int DT_W    = 17;
	localparam int HALF_W  = 16;

	// request modes
	localparam logic MODE_TIME = 1'b0;
	localparam logic MODE_STIM = 1'b1;

	// Q16.16 model constants
	localparam logic signed [33:0] K_004  = 34'sd2621;
	localparam logic signed [33:0] K_02   = 34'sd13107;
	localparam logic signed [28:0] K_5    = 29'sd327680;
	localparam logic signed [44:0] K_140  = 45'sd9175040;
	localparam logic signed [31:0] V_PEAK = 32'sd1966080;
	localparam logic signed [31:0] V_REST = -32'sd4587520;
	localparam logic signed [31:0] U_REST = -32'sd917490;
	localparam logic [DT_W-1:0]    DT_MAX = 17'd65536;
	localparam logic [HALF_W-1:0]  H_MAX  = 16'd32768;

	// configuration register reset values
	localparam logic signed [31:0] A_RST = 32'sd1311;
	localparam logic signed [31:0] B_RST = 32'sd13107;
	localparam logic signed [31:0] C_RST = -32'sd4259840;
	localparam logic signed [31:0] D_RST = 32'sd524288;

	// saturation bounds
	localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
	localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

	typedef enum logic [1:0] {
		CFG_A = 2'd0,
		CFG_B = 2'd1,
		CFG_C = 2'd2,
		CFG_D = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] d;
	} cfg_t;

	typedef struct packed {
		logic               mode;
		logic [31:0]        elapsed_ticks;
		logic [31:0]        drift_ticks;
		logic signed [31:0] current_amount;
	} in_item_t;

	typedef struct packed {
		logic               spiked;
		logic [31:0]        spike_time;
		logic [10:0]        ticks_taken;
		logic signed [31:0] membrane_potential;
	} out_item_t;

	// classified request handed from front to back
	typedef struct packed {
		logic               stim;
		logic [TICKS_W-1:0] ticks;
		logic [31:0]        stamp;
		logic signed [31:0] cur;
	} cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
		logic signed [31:0] r;
		if (x > SAT_HI) begin
			r = 32'sh7fffffff;
		end else if (x < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

FILE: hdl/izh_fifo.sv
// small register queue with full and empty flags
`timescale 1ns / 1ps

module izh_fifo
	import izh_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             wr_fire;
	logic             rd_fire;

	// flags and handshakes
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_fire = wr_en && !full;
	assign rd_fire = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_fire) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd_fire) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr_fire && !rd_fire) begin
				count_q <= count_q + 1'b1;
			end else if (rd_fire && !wr_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/izh_front.sv
// request front end: clamps ticks, forms the spike stamp and queues commands
`timescale 1ns / 1ps

module izh_front
	import izh_pkg::*;
#(
	parameter int TICK_RATE   = TICK_RATE_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	output logic     full,
	input  logic     cmd_pop,
	output cmd_t     cmd,
	output logic     cmd_empty
);

	localparam logic [TICKS_W-1:0] TPM_C = TICKS_W'(TICK_RATE);

	cmd_t               cmd_in;
	logic [TICKS_W-1:0] ticks;

	// clamp elapsed time to one millisecond, stimulus advances nothing
	always_comb begin
		ticks = '0;
		if (item.mode == MODE_TIME) begin
			if (item.elapsed_ticks > 32'(TPM_C)) begin
				ticks = TPM_C;
			end else begin
				ticks = item.elapsed_ticks[TICKS_W-1:0];
			end
		end
		cmd_in.stim  = (item.mode == MODE_STIM);
		cmd_in.ticks = ticks;
		cmd_in.stamp = item.drift_ticks + 32'(ticks);
		cmd_in.cur   = item.current_amount;
	end

	// command queue towards the back end
	izh_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(cmd_in),
		.full   (full),
		.rd_en  (cmd_pop),
		.rd_data(cmd),
		.empty  (cmd_empty)
	);

endmodule

FILE: hdl/izh_back.sv
// neuron state and sequencer around one shared 34x34 multiplier
`timescale 1ns / 1ps

module izh_back
	import izh_pkg::*;
#(
	parameter int TICK_RATE = TICK_RATE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  cmd_t      cmd,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	input  logic      res_full,
	output logic      res_push,
	output out_item_t res
);

	// reciprocal of the tick rate, quotient exact or one short
	localparam logic [32:0]        RECIP = 33'((64'd1 << 32) / TICK_RATE);
	localparam logic [TICKS_W-1:0] TPM_C = TICKS_W'(TICK_RATE);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DT0, ST_DT1, ST_DT2,
		ST_V0, ST_V1, ST_V2, ST_V3, ST_V4, ST_V5, ST_V6,
		ST_U0, ST_U1, ST_U2, ST_U3, ST_U4,
		ST_SPK,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic signed [31:0] v_q;
	logic signed [31:0] u_q;
	logic signed [31:0] iapp_q;
	logic [TICKS_W-1:0] ticks_q;
	logic [31:0]        stamp_q;
	logic signed [31:0] cur_q;
	logic [DT_W-1:0]    qe_q;
	logic [DT_W-1:0]    dt_q;
	logic [HALF_W-1:0]  h_q;
	logic               half_q;
	logic signed [28:0] t_q;
	logic signed [44:0] d_q;
	logic signed [44:0] acc_q;
	logic signed [32:0] ta_q;
	logic signed [32:0] diff_q;
	logic signed [67:0] p_q;
	out_item_t          res_q;

	logic signed [33:0] ma;
	logic signed [33:0] mb;
	logic signed [67:0] prod;
	logic [33:0]        num;
	logic [33:0]        rem;
	logic [DT_W-1:0]    dt_next;
	logic signed [62:0] vsum;
	logic signed [31:0] v_next;
	logic signed [31:0] u_next;

	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
	assign res_push = (state_q == ST_OUT) && !res_full;
	assign res      = res_q;

	// operand selection for the shared multiplier, registered operands only
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_DT0: begin
				ma = 34'(ticks_q);
				mb = 34'(RECIP);
			end
			ST_DT1: begin
				ma = 34'(p_q[32:16]);
				mb = 34'(TPM_C);
			end
			ST_V0: begin
				ma = K_004;
				mb = 34'(v_q);
			end
			ST_V2: begin
				ma = 34'(t_q);
				mb = 34'(v_q);
			end
			ST_V4: begin
				ma = 34'(h_q);
				mb = 34'($signed(d_q[44:17]));
			end
			ST_V5: begin
				ma = 34'(h_q);
				mb = 34'(d_q[16:0]);
			end
			ST_U0: begin
				ma = 34'(dt_q);
				mb = 34'(cfg.a);
			end
			ST_U1: begin
				ma = K_02;
				mb = 34'(v_q);
			end
			ST_U3: begin
				ma = 34'(ta_q);
				mb = 34'(diff_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = ma * mb;

	// step correction, half step sum and recovery update
	always_comb begin
		num     = 34'(ticks_q) << 16;
		rem     = num - p_q[33:0];
		dt_next = qe_q + DT_W'(rem >= 34'(TPM_C));
		vsum    = (63'(acc_q) <<< 17) + 63'(p_q);
		v_next  = sat32(68'(v_q) + 68'(vsum >>> 16));
		u_next  = sat32(68'(u_q) + (p_q >>> 16));
	end

	// sequencer, neuron state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_q     <= V_REST;
			u_q     <= U_REST;
			iapp_q  <= '0;
			ticks_q <= '0;
			stamp_q <= '0;
			cur_q   <= '0;
			qe_q    <= '0;
			dt_q    <= '0;
			h_q     <= '0;
			half_q  <= 1'b0;
			t_q     <= '0;
			d_q     <= '0;
			acc_q   <= '0;
			ta_q    <= '0;
			diff_q  <= '0;
			p_q     <= '0;
			res_q   <= '0;
		end else begin
			p_q <= prod;
			case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						ticks_q <= cmd.ticks;
						stamp_q <= cmd.stamp;
						cur_q   <= cmd.cur;
						if (cmd.stim) begin
							// stimulus adds to the applied current
							iapp_q  <= sat32(68'(iapp_q) + 68'(cmd.cur));
							res_q   <= '{spiked: 1'b0, spike_time: '0, ticks_taken: '0,
								membrane_potential: v_q};
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_DT0;
						end
					end
				end
				ST_DT0: begin
					state_q <= ST_DT1;
				end
				ST_DT1: begin
					qe_q    <= p_q[32:16];
					state_q <= ST_DT2;
				end
				ST_DT2: begin
					dt_q    <= dt_next;
					h_q     <= dt_next[DT_W-1:1];
					half_q  <= 1'b0;
					state_q <= ST_V0;
				end
				ST_V0: begin
					state_q <= ST_V1;
				end
				ST_V1: begin
					t_q     <= 29'(p_q >>> 16) + K_5;
					state_q <= ST_V2;
				end
				ST_V2: begin
					state_q <= ST_V3;
				end
				ST_V3: begin
					d_q     <= 45'(p_q >>> 16) + K_140 - 45'(u_q) + 45'(cur_q) + 45'(iapp_q);
					state_q <= ST_V4;
				end
				ST_V4: begin
					state_q <= ST_V5;
				end
				ST_V5: begin
					acc_q   <= 45'(p_q);
					state_q <= ST_V6;
				end
				ST_V6: begin
					v_q <= v_next;
					if (!half_q) begin
						// second half takes the rest of the step
						h_q     <= HALF_W'(dt_q - DT_W'(h_q));
						half_q  <= 1'b1;
						state_q <= ST_V0;
					end else begin
						state_q <= ST_U0;
					end
				end
				ST_U0: begin
					state_q <= ST_U1;
				end
				ST_U1: begin
					ta_q    <= 33'(p_q >>> 16);
					state_q <= ST_U2;
				end
				ST_U2: begin
					diff_q  <= 33'(p_q >>> 16) - 33'(u_q);
					state_q <= ST_U3;
				end
				ST_U3: begin
					state_q <= ST_U4;
				end
				ST_U4: begin
					u_q <= u_next;
					if (v_q >= V_PEAK) begin
						state_q <= ST_SPK;
					end else begin
						res_q   <= '{spiked: 1'b0, spike_time: '0,
							ticks_taken: 11'(ticks_q), membrane_potential: v_q};
						state_q <= ST_OUT;
					end
				end
				ST_SPK: begin
					// spike resets the potential and kicks the recovery
					v_q     <= cfg.c;
					u_q     <= sat32(68'(u_q) + 68'(cfg.d));
					res_q   <= '{spiked: 1'b1, spike_time: stamp_q,
						ticks_taken: 11'(ticks_q), membrane_potential: cfg.c};
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a popped command always starts work
	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (state_q != ST_IDLE))
		else $error("popped command did not start");

	// reciprocal estimate is never more than one short
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DT2) |-> (rem < (34'(TPM_C) << 1)))
		else $error("step remainder out of range");

	// step stays within one millisecond
	a_dt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_V0) |-> (dt_q <= DT_MAX))
		else $error("step above one millisecond");

	// each half step is at most half a millisecond
	a_half_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_V4) |-> (h_q <= H_MAX))
		else $error("half step too large");

	// potential returns to c after a spike
	a_spike_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPK) |=> (v_q == $past(cfg.c)))
		else $error("spike did not reset potential");

endmodule

FILE: hdl/izhikevich_neuron_step.sv
// izhikevich neuron step: top level with configuration registers and queues
// Usage:
// - Requests enter through push/full with payload item; a request is taken at
//   a clock edge where push is high and full is low. Mode 0 advances time by
//   the elapsed ticks (clamped to one millisecond), mode 1 adds a stimulus.
// - Results leave through empty/pop with payload result; the oldest result
//   is shown while empty is low and is taken where pop is high.
// - Parameters a, b, c, d are written over cfg_valid/cfg_index/cfg_data;
//   cfg_ready is always high. Write them only while the block is idle.
// - A front end clamps ticks and forms the spike stamp into a command queue;
//   the back end runs one request at a time around a shared multiplier.
// - A stimulus request goes from the command straight to its result in the back
//   end; a time request runs the multiply chain of the two half steps and the
//   recovery update through the single multiplier, plus a spike state if it spikes.
// - If the receiver stops popping, the result queue fills, the back end
//   holds its finished result and the command queue then raises full.
// - Reset puts v at -70, u at -14.0 (reset b times -70), the applied current
//   at 0, the registers at their defaults and both queues empty.
`timescale 1ns / 1ps

module izhikevich_neuron_step
	import izh_pkg::*;
#(
	parameter int TICK_RATE   = TICK_RATE_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_item_t  item,
	output logic      full,
	output logic      empty,
	input  logic      pop,
	output out_item_t result,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_reg_t  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t      cfg_q;
	cmd_t      cmd;
	logic      cmd_empty;
	logic      cmd_pop;
	logic      res_full;
	logic      res_push;
	out_item_t res;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a <= A_RST;
			cfg_q.b <= B_RST;
			cfg_q.c <= C_RST;
			cfg_q.d <= D_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_A:   cfg_q.a <= cfg_data;
				CFG_B:   cfg_q.b <= cfg_data;
				CFG_C:   cfg_q.c <= cfg_data;
				CFG_D:   cfg_q.d <= cfg_data;
				default: cfg_q   <= cfg_q;
			endcase
		end
	end

	// request classification and command queue
	izh_front #(
		.TICK_RATE  (TICK_RATE),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	// neuron arithmetic
	izh_back #(
		.TICK_RATE(TICK_RATE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// result queue towards the receiver
	izh_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(result),
		.empty  (empty)
	);

endmodule
